// ----- rtl/wex_pkg.sv -----
package wex_pkg;

  localparam int WINDOW      = 256;
  localparam int SAMPLE_BITS = 10;
  localparam int ADDR_W      = $clog2(WINDOW);
  localparam int CNT_W       = $clog2(WINDOW + 1);
  localparam int THR_W       = 14;
  localparam int FREQ_W      = 16;

  localparam logic [FREQ_W-1:0] COUNT_MAX = {FREQ_W{1'b1}};

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [THR_W-1:0]       thr_t;
  typedef logic [FREQ_W-1:0]      freq_t;

  typedef struct packed {
    logic    done;
    sample_t lo;
    sample_t hi;
  } scan_res_t;

  typedef struct packed {
    sample_t window_min;
    sample_t window_max;
    sample_t peak_to_peak;
    thr_t    low_threshold_x10;
    thr_t    high_threshold_x10;
    logic    above_high;
    freq_t   frequency;
  } hyst_res_t;

  function automatic thr_t times_ten(input sample_t v);
    return (thr_t'(v) << 3) + (thr_t'(v) << 1);
  endfunction

  function automatic thr_t times_nine(input sample_t v);
    return (thr_t'(v) << 3) + thr_t'(v);
  endfunction

endpackage

// ----- rtl/wex_in_if.sv -----
interface wex_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] sample;
  logic       gate_end;

  modport source (output valid, output sample, output gate_end, input ready);
  modport sink   (input valid, input sample, input gate_end, output ready);
endinterface

// ----- rtl/wex_out_if.sv -----
interface wex_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  window_min;
  logic [9:0]  window_max;
  logic [9:0]  peak_to_peak;
  logic [13:0] low_threshold_x10;
  logic [13:0] high_threshold_x10;
  logic        above_high;
  logic [15:0] frequency;

  modport source (output valid, output window_min, output window_max, output peak_to_peak,
                  output low_threshold_x10, output high_threshold_x10, output above_high,
                  output frequency, input ready);
  modport sink   (input valid, input window_min, input window_max, input peak_to_peak,
                  input low_threshold_x10, input high_threshold_x10, input above_high,
                  input frequency, output ready);
endinterface

// ----- rtl/wex_scan.sv -----
module wex_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  wex_pkg::sample_t   sample,
  output wex_pkg::scan_res_t res
);

  wex_pkg::sample_t ring [wex_pkg::WINDOW];
  wex_pkg::sample_t rd_data;

  logic [wex_pkg::ADDR_W-1:0] write_position;
  logic [wex_pkg::ADDR_W-1:0] addr;
  logic [wex_pkg::CNT_W-1:0]  fill_count;
  logic [wex_pkg::CNT_W-1:0]  fill_next;
  logic [wex_pkg::CNT_W-1:0]  remaining;
  logic                       busy;
  logic                       rd_vld;
  wex_pkg::sample_t           lo;
  wex_pkg::sample_t           hi;

  assign fill_next = (fill_count < wex_pkg::CNT_W'(wex_pkg::WINDOW)) ?
                     fill_count + 1'b1 : fill_count;

  always_ff @(posedge clk) begin
    if (start) begin
      ring[write_position] <= sample;
    end
    rd_data <= ring[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      fill_count     <= '0;
      remaining      <= '0;
      busy           <= 1'b0;
      rd_vld         <= 1'b0;
      addr           <= '0;
      lo             <= '0;
      hi             <= '0;
    end else if (start) begin
      fill_count     <= fill_next;
      remaining      <= fill_next;
      addr           <= write_position;
      write_position <= (write_position == wex_pkg::ADDR_W'(wex_pkg::WINDOW - 1)) ?
                        '0 : write_position + 1'b1;
      busy           <= 1'b1;
      rd_vld         <= 1'b0;
      lo             <= '1;
      hi             <= '0;
    end else if (busy) begin
      // issue one read per cycle, walking backward from the newest entry
      if (remaining != '0) begin
        remaining <= remaining - 1'b1;
        addr      <= (addr == '0) ? wex_pkg::ADDR_W'(wex_pkg::WINDOW - 1) : addr - 1'b1;
        rd_vld    <= 1'b1;
      end else begin
        rd_vld <= 1'b0;
      end
      if (rd_vld) begin
        if (rd_data < lo) lo <= rd_data;
        if (rd_data > hi) hi <= rd_data;
      end
      if (remaining == '0 && !rd_vld) begin
        busy <= 1'b0;
      end
    end
  end

  assign res.done = busy && remaining == '0 && !rd_vld;
  assign res.lo   = lo;
  assign res.hi   = hi;

endmodule

// ----- rtl/wex_hyst.sv -----
module wex_hyst (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  wex_pkg::sample_t   lo,
  input  wex_pkg::sample_t   hi,
  input  wex_pkg::sample_t   sample,
  input  logic               gate,
  output logic               done,
  output wex_pkg::hyst_res_t res
);

  logic             calc;
  logic             gate_q;
  wex_pkg::thr_t    s10;
  wex_pkg::thr_t    low10;
  wex_pkg::thr_t    high10;
  wex_pkg::sample_t lo_q;
  wex_pkg::sample_t hi_q;
  wex_pkg::sample_t span;
  logic             is_above;
  logic             is_above_next;
  wex_pkg::freq_t   crossing_counter;
  wex_pkg::freq_t   crossing_next;
  wex_pkg::freq_t   latched_frequency;

  always_comb begin
    is_above_next = is_above;
    crossing_next = crossing_counter;
    if (!is_above && s10 >= high10) begin
      is_above_next = 1'b1;
      if (crossing_counter != wex_pkg::COUNT_MAX) crossing_next = crossing_counter + 1'b1;
    end else if (is_above && s10 <= low10) begin
      is_above_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      lo_q   <= lo;
      hi_q   <= hi;
      span   <= hi - lo;
      low10  <= wex_pkg::times_ten(lo) + wex_pkg::thr_t'(hi - lo);
      high10 <= wex_pkg::times_ten(lo) + wex_pkg::times_nine(hi - lo);
      s10    <= wex_pkg::times_ten(sample);
      gate_q <= gate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calc              <= 1'b0;
      done              <= 1'b0;
      is_above          <= 1'b0;
      crossing_counter  <= '0;
      latched_frequency <= '0;
    end else begin
      calc <= go;
      done <= calc;
      if (calc) begin
        is_above <= is_above_next;
        if (gate_q) begin
          latched_frequency <= crossing_next;
          crossing_counter  <= '0;
        end else begin
          crossing_counter  <= crossing_next;
        end
      end
    end
  end

  assign res.window_min         = lo_q;
  assign res.window_max         = hi_q;
  assign res.peak_to_peak       = span;
  assign res.low_threshold_x10  = low10;
  assign res.high_threshold_x10 = high10;
  assign res.above_high         = is_above;
  assign res.frequency          = latched_frequency;

endmodule

// ----- rtl/window_extremes_hysteresis_freq.sv -----
// Each accepted item is written into the sample ring, which is then scanned serially
// through its single read port over fill_count entries (fill_count <= 256); the input
// waits while a scan runs and until the thresholds and frequency are computed.
// A pending result may sit in the output register while the next item is taken.
// Reset (rst, synchronous): empties the window, clears the flag, counter and frequency.
module window_extremes_hysteresis_freq (
  input  logic clk,
  input  logic rst,
  wex_in_if.sink    sample_ch,
  wex_out_if.source result_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ARM  = 4'b0100,
    S_CALC = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic               accept;
  logic               go;
  logic               hyst_done;
  logic               out_valid;
  logic               gate;
  wex_pkg::sample_t   sample;
  wex_pkg::scan_res_t scan_res;
  wex_pkg::hyst_res_t hyst_res;

  assign sample_ch.ready = state == S_IDLE && !rst;
  assign accept          = sample_ch.valid && sample_ch.ready;
  assign go              = state == S_ARM && (!out_valid || result_ch.ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= sample_ch.sample[wex_pkg::SAMPLE_BITS-1:0];
      gate   <= sample_ch.gate_end;
    end
  end

  wex_scan u_scan (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .sample (sample_ch.sample[wex_pkg::SAMPLE_BITS-1:0]),
    .res    (scan_res)
  );

  wex_hyst u_hyst (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .lo     (scan_res.lo),
    .hi     (scan_res.hi),
    .sample (sample),
    .gate   (gate),
    .done   (hyst_done),
    .res    (hyst_res)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (scan_res.done) state_next = S_ARM;
      S_ARM:   if (go) state_next = S_CALC;
      S_CALC:  if (hyst_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (hyst_done) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_ch.valid              = out_valid;
  assign result_ch.window_min         = hyst_res.window_min;
  assign result_ch.window_max         = hyst_res.window_max;
  assign result_ch.peak_to_peak       = hyst_res.peak_to_peak;
  assign result_ch.low_threshold_x10  = hyst_res.low_threshold_x10;
  assign result_ch.high_threshold_x10 = hyst_res.high_threshold_x10;
  assign result_ch.above_high         = hyst_res.above_high;
  assign result_ch.frequency          = hyst_res.frequency;

  assert property (@(posedge clk) disable iff (rst) accept |=> state == S_SCAN)
    else $error("accepted item did not start a scan");

  assert property (@(posedge clk) disable iff (rst) hyst_done |-> state == S_CALC)
    else $error("threshold result outside its slot");

  assert property (@(posedge clk) disable iff (rst)
                   result_ch.valid |-> result_ch.window_min <= result_ch.window_max)
    else $error("window minimum above maximum");

  assert property (@(posedge clk) disable iff (rst)
                   result_ch.valid |->
                   result_ch.peak_to_peak == result_ch.window_max - result_ch.window_min)
    else $error("span does not match extremes");

endmodule
